[design/detector_pairing_table_macros.svh]
// Assertion shorthands for the pairing table checker.
// Each expects clk and rst_n in the scope where it is used.
`ifndef DETECTOR_PAIRING_TABLE_MACROS_SVH
`define DETECTOR_PAIRING_TABLE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define DPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/dpt_pkg.sv]
`timescale 1ns / 1ps
package dpt_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int ADDR_W          = 8;
  localparam logic [7:0] NO_HIT_VALUE = 8'hFF;

  typedef enum logic [1:0] {
    OP_MATCH = 2'd0,
    OP_LEARN = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_HIT = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] id;
    logic       mark;
    logic [7:0] name_num;
    logic [7:0] dtype;
    logic [7:0] zone;
    logic [7:0] code_low;
    logic [7:0] code_mid;
    logic [7:0] code_high;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } store_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } store_rd_t;

endpackage

[design/dpt_if.sv]
`timescale 1ns / 1ps
interface dpt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] table_index;
  logic [7:0] entry_id;
  logic       entry_mark;
  logic [7:0] name_number;
  logic [7:0] detector_type;
  logic [7:0] zone_kind;
  logic [7:0] code_low;
  logic [7:0] code_mid;
  logic [7:0] code_high;

  modport source (
    output valid, opcode, table_index, entry_id, entry_mark, name_number,
           detector_type, zone_kind, code_low, code_mid, code_high,
    input  ready
  );
  modport sink (
    input  valid, opcode, table_index, entry_id, entry_mark, name_number,
           detector_type, zone_kind, code_low, code_mid, code_high,
    output ready
  );
endinterface

interface dpt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] result_value;
  logic [7:0] out_id;
  logic       out_mark;
  logic [7:0] out_name_number;
  logic [7:0] out_detector_type;
  logic [7:0] out_zone_kind;
  logic [7:0] out_code_low;
  logic [7:0] out_code_mid;
  logic [7:0] out_code_high;

  modport source (
    output valid, status, result_value, out_id, out_mark, out_name_number,
           out_detector_type, out_zone_kind, out_code_low, out_code_mid,
           out_code_high,
    input  ready
  );
  modport sink (
    input  valid, status, result_value, out_id, out_mark, out_name_number,
           out_detector_type, out_zone_kind, out_code_low, out_code_mid,
           out_code_high,
    output ready
  );
endinterface

[design/detector_pairing_table.sv]
`timescale 1ns / 1ps
// Pairing table for wireless detectors: TABLE_DEPTH entries, each with id, mark,
// name number, detector type, zone type and a three-byte radio code, all zero
// after reset (per-entry valid bits, no clearing pass). Match and learn sweep
// the single read port of the table one entry per cycle; read makes a single
// table access and write goes straight to its finish state. One operation is
// in flight at a time; a finished result sits in the output register, so a
// new item is taken while it waits.
module detector_pairing_table #(
  parameter int TABLE_DEPTH = dpt_pkg::TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dpt_in_if.sink    in_chan,
  dpt_out_if.source out_chan
);
  import dpt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [7:0]       DEPTH8   = 8'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_RDREQ  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic             out_vld_r, out_vld_nxt;
  opcode_t          op_r;
  logic [7:0]       idx_r;
  entry_t           item_r;
  logic [CNT_W-1:0] cnt_r;
  logic             chk_vld_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic             hit_found_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [7:0]       hit_id_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  status_t          status_r;
  logic [7:0]       result_r;
  entry_t           out_entry_r;

  logic      accept;
  logic      in_range;
  logic      finish_go;
  logic      is_hit;
  store_wr_t wr;
  store_rd_t rd;
  entry_t    rd_data;
  status_t   res_status;
  logic [7:0] res_value;
  entry_t    res_entry;

  dpt_store #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign in_range      = (idx_r < DEPTH8);
  assign finish_go     = (state_r == S_FINISH) && (!out_vld_r || out_chan.ready);
  assign is_hit        = rd_data.mark && (rd_data.code_mid == item_r.code_mid)
                         && (rd_data.code_high == item_r.code_high);

  always_comb begin
    rd.en   = 1'b0;
    rd.addr = idx_r;
    if (state_r == S_SCAN) begin
      rd.en   = (cnt_r != LAST_CNT);
      rd.addr = ADDR_W'(cnt_r);
    end else if (state_r == S_RDREQ) begin
      rd.en = in_range;
    end
  end

  // Result and table update for the operation being retired.
  always_comb begin
    res_status = ST_OK;
    res_value  = '0;
    res_entry  = '0;
    wr.en      = 1'b0;
    wr.addr    = idx_r;
    wr.data    = item_r;
    unique case (op_r)
      OP_MATCH: begin
        if (hit_found_r) begin
          res_value = hit_id_r;
        end else begin
          res_status = ST_NO_HIT;
          res_value  = NO_HIT_VALUE;
        end
      end
      OP_LEARN: begin
        if (hit_found_r) begin
          res_value = 8'(hit_idx_r);
        end else if (free_found_r) begin
          res_value        = 8'(free_idx_r);
          wr.en            = finish_go;
          wr.addr          = 8'(free_idx_r);
          wr.data.id       = 8'(free_idx_r) + 8'd1;
          wr.data.name_num = 8'(free_idx_r) + 8'd1;
          wr.data.mark     = 1'b1;
        end else begin
          res_status = ST_NO_HIT;
          res_value  = NO_HIT_VALUE;
        end
      end
      OP_READ: begin
        if (in_range) begin
          res_entry = rd_data;
        end else begin
          res_status = ST_RANGE;
        end
      end
      OP_WRITE: begin
        if (in_range) begin
          wr.en = finish_go;
        end else begin
          res_status = ST_RANGE;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    out_vld_nxt = out_vld_r && !out_chan.ready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode_t'(in_chan.opcode)) inside
            OP_MATCH, OP_LEARN: state_nxt = S_SCAN;
            OP_READ:            state_nxt = S_RDREQ;
            default:            state_nxt = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        if (cnt_r == LAST_CNT) begin
          state_nxt = S_FINISH;
        end
      end
      S_RDREQ: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (finish_go) begin
          state_nxt   = S_IDLE;
          out_vld_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= opcode_t'(in_chan.opcode);
      idx_r        <= in_chan.table_index;
      item_r       <= '{id: in_chan.entry_id, mark: in_chan.entry_mark,
                        name_num: in_chan.name_number, dtype: in_chan.detector_type,
                        zone: in_chan.zone_kind, code_low: in_chan.code_low,
                        code_mid: in_chan.code_mid, code_high: in_chan.code_high};
      cnt_r        <= '0;
      chk_vld_r    <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (state_r == S_SCAN) begin
      // Read data arrives in the cycle after its address; tag it with its index.
      chk_vld_r <= (cnt_r != LAST_CNT);
      chk_idx_r <= cnt_r[IDX_W-1:0];
      if (cnt_r != LAST_CNT) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (chk_vld_r && is_hit && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= chk_idx_r;
        hit_id_r    <= rd_data.id;
      end
      if (chk_vld_r && !rd_data.mark && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= chk_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      status_r    <= res_status;
      result_r    <= res_value;
      out_entry_r <= res_entry;
    end
  end

  assign out_chan.valid             = out_vld_r;
  assign out_chan.status            = status_r;
  assign out_chan.result_value      = result_r;
  assign out_chan.out_id            = out_entry_r.id;
  assign out_chan.out_mark          = out_entry_r.mark;
  assign out_chan.out_name_number   = out_entry_r.name_num;
  assign out_chan.out_detector_type = out_entry_r.dtype;
  assign out_chan.out_zone_kind     = out_entry_r.zone;
  assign out_chan.out_code_low      = out_entry_r.code_low;
  assign out_chan.out_code_mid      = out_entry_r.code_mid;
  assign out_chan.out_code_high     = out_entry_r.code_high;

endmodule

[design/dpt_store.sv]
`timescale 1ns / 1ps
module dpt_store #(
  parameter int DEPTH = dpt_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W = $clog2(dpt_pkg::TABLE_DEPTH_DEF)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dpt_pkg::store_wr_t wr,
  input  dpt_pkg::store_rd_t rd,
  output dpt_pkg::entry_t    rd_data
);
  import dpt_pkg::*;

  entry_t           mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  entry_t           rd_q_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] wa;
  logic [IDX_W-1:0] ra;

  assign wa = wr.addr[IDX_W-1:0];
  assign ra = rd.addr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wa] <= wr.data;
    end
    if (rd.en) begin
      rd_q_r <= mem_r[ra];
    end
  end

  // An entry never written since reset reads as all zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wa] <= 1'b1;
      end
      if (rd.en) begin
        rd_vld_r <= vld_r[ra];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

[design/dpt_checker.sv]
`timescale 1ns / 1ps
`include "detector_pairing_table_macros.svh"
module dpt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [7:0] out_result_value,
  input logic       out_mark
);
  import dpt_pkg::*;

  // Hold a stalled result.
  `DPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  // Drop ready after a transfer: one operation at a time.
  `DPT_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input taken while busy")
  `DPT_ASSERT_NOW(a_no_hit_value, out_valid && (out_status == ST_NO_HIT), out_result_value == NO_HIT_VALUE, "no-hit result without 0xFF")
  `DPT_ASSERT_NOW(a_range_clean, out_valid && (out_status == ST_RANGE), (out_result_value == 8'd0) && !out_mark, "range error carries data")

endmodule

bind detector_pairing_table dpt_checker u_dpt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_status       (out_chan.status),
  .out_result_value (out_chan.result_value),
  .out_mark         (out_chan.out_mark)
);
